FILE: rtl/core/cbz_pkg.sv
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared widths, register codes and sideband types for the cubic Bezier
// point and tangent evaluator.
// ----------------------------------------------------------------------------
package cbz_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int PARAM_BITS  = 16;
  localparam int CP_WIDTH    = 60;
  localparam int ADDR_WIDTH  = 5;
  localparam int DATA_WIDTH  = 64;
  localparam int NORM_BITS   = 30;
  localparam int TAN_WIDTH   = 16;
  localparam int QUOT_BITS   = 15;

  typedef enum logic [1:0] {
    REG_CP0,
    REG_CP1,
    REG_CP2,
    REG_CP3
  } reg_idx_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } tan_flags_t;

endpackage

FILE: rtl/core/cbz_casteljau.sv
// ----------------------------------------------------------------------------
// cbz_casteljau
// Three interpolation levels of de Casteljau's construction, one level per
// stage, then the curve point and the magnitude and sign of e - d.
// ----------------------------------------------------------------------------
module cbz_casteljau #(
  parameter int CW = cbz_pkg::COORD_WIDTH,
  parameter int PB = cbz_pkg::PARAM_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [PB:0]             in_t,
  input  logic [3:0][2:0][CW-1:0] cp,
  output logic                    out_valid,
  output logic [2:0][CW-1:0]      out_point,
  output logic [2:0][CW:0]        out_mag,
  output cbz_pkg::tan_flags_t     out_flags
);

  localparam int PW = CW + PB + 3;
  localparam logic [PB:0] T_ONE = (PB + 1)'(1) << PB;
  localparam logic signed [PW-1:0] RND = PW'(1) << (PB - 1);

  function automatic logic [CW-1:0] lerp(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                         input logic [PB:0] t);
    logic signed [CW:0]   d;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] r;
    d    = (CW + 1)'($signed(b)) - (CW + 1)'($signed(a));
    prod = PW'(d) * PW'($signed({1'b0, t}));
    r    = (prod + RND) >>> PB;
    return CW'(PW'($signed(a)) + r);
  endfunction

  logic                v1_r, v2_r, v3_r, v4_r;
  logic [PB:0]         t1_r, t2_r, t3_r;
  logic [2:0][CW-1:0]  a_r, b_r, c_r, d_r, e_r, point_r;
  logic [2:0][CW:0]    mag_r, mag_nxt, diff_nxt;
  cbz_pkg::tan_flags_t flags_r, flags_nxt;

  always_comb begin
    flags_nxt.degen = 1'b1;
    for (int k = 0; k < 3; k++) begin
      diff_nxt[k] = (CW + 1)'($signed(e_r[k])) - (CW + 1)'($signed(d_r[k]));
      flags_nxt.neg[k] = diff_nxt[k][CW];
      mag_nxt[k] = diff_nxt[k][CW] ? (CW + 1)'(-diff_nxt[k]) : diff_nxt[k];
      if (diff_nxt[k] != '0) begin
        flags_nxt.degen = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= (in_t > T_ONE) ? T_ONE : in_t;
      t2_r <= t1_r;
      t3_r <= t2_r;
      for (int k = 0; k < 3; k++) begin
        a_r[k]     <= lerp(cp[0][k], cp[1][k], t1_r);
        b_r[k]     <= lerp(cp[1][k], cp[2][k], t1_r);
        c_r[k]     <= lerp(cp[2][k], cp[3][k], t1_r);
        d_r[k]     <= lerp(a_r[k], b_r[k], t2_r);
        e_r[k]     <= lerp(b_r[k], c_r[k], t2_r);
        point_r[k] <= lerp(d_r[k], e_r[k], t3_r);
      end
      mag_r   <= mag_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_point = point_r;
  assign out_mag   = mag_r;
  assign out_flags = flags_r;

endmodule

FILE: rtl/core/cbz_normalize.sv
// ----------------------------------------------------------------------------
// cbz_normalize
// Scales the tangent difference so its largest magnitude has its top bit at
// NB-1, then squares and sums the three components.
// ----------------------------------------------------------------------------
module cbz_normalize #(
  parameter int CW = cbz_pkg::COORD_WIDTH,
  parameter int NB = cbz_pkg::NORM_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [2:0][CW-1:0]      in_point,
  input  logic [2:0][CW:0]        in_mag,
  input  cbz_pkg::tan_flags_t     in_flags,
  output logic                    out_valid,
  output logic [2*NB+1:0]         out_sum,
  output logic [2:0][NB-1:0]      out_nm,
  output logic [2:0][CW-1:0]      out_point,
  output cbz_pkg::tan_flags_t     out_flags
);

  localparam int SW   = 2 * NB + 2;
  localparam int MSBW = $clog2(CW + 1);
  localparam int XW   = CW + 1 + NB;

  logic [3:0]               v_r;
  logic [2:0][CW-1:0]       pt_r [4];
  cbz_pkg::tan_flags_t      fl_r [4];
  logic [2:0][CW:0]         mag5_r;
  logic [MSBW-1:0]          msb5_r, msb_nxt;
  logic [2:0][NB-1:0]       nm6_r, nm7_r, nm8_r, nm_nxt;
  logic [2:0][2*NB-1:0]     sq7_r;
  logic [SW-1:0]            sum8_r;
  logic [CW:0]              or_all;

  always_comb begin
    or_all  = in_mag[0] | in_mag[1] | in_mag[2];
    msb_nxt = '0;
    for (int i = 0; i <= CW; i++) begin
      if (or_all[i]) begin
        msb_nxt = MSBW'(i);
      end
    end
  end

  always_comb begin
    logic [XW-1:0] x;
    int            sh;
    sh = (NB - 1) - int'(msb5_r);
    for (int k = 0; k < 3; k++) begin
      if (sh < 0) begin
        x = XW'(mag5_r[k]) >> (-sh);
      end else begin
        x = XW'(mag5_r[k]) << sh;
      end
      nm_nxt[k] = x[NB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r[0] <= in_point;
      fl_r[0] <= in_flags;
      for (int s = 1; s < 4; s++) begin
        pt_r[s] <= pt_r[s-1];
        fl_r[s] <= fl_r[s-1];
      end
      mag5_r <= in_mag;
      msb5_r <= msb_nxt;
      nm6_r  <= nm_nxt;
      nm7_r  <= nm6_r;
      nm8_r  <= nm7_r;
      for (int k = 0; k < 3; k++) begin
        sq7_r[k] <= nm6_r[k] * nm6_r[k];
      end
      sum8_r <= SW'(sq7_r[0]) + SW'(sq7_r[1]) + SW'(sq7_r[2]);
    end
  end

  assign out_valid = v_r[3];
  assign out_sum   = sum8_r;
  assign out_nm    = nm8_r;
  assign out_point = pt_r[3];
  assign out_flags = fl_r[3];

endmodule

FILE: rtl/core/cbz_isqrt.sv
// ----------------------------------------------------------------------------
// cbz_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cbz_isqrt #(
  parameter int CW = cbz_pkg::COORD_WIDTH,
  parameter int NB = cbz_pkg::NORM_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [2*NB+1:0]         in_sum,
  input  logic [2:0][NB-1:0]      in_nm,
  input  logic [2:0][CW-1:0]      in_point,
  input  cbz_pkg::tan_flags_t     in_flags,
  output logic                    out_valid,
  output logic [NB:0]             out_len,
  output logic [2:0][NB-1:0]      out_nm,
  output logic [2:0][CW-1:0]      out_point,
  output cbz_pkg::tan_flags_t     out_flags
);

  localparam int SW     = 2 * NB + 2;
  localparam int STEPS  = SW / 2;
  localparam int SIDE_W = 3 * NB + 3 * CW + $bits(cbz_pkg::tan_flags_t);

  logic [STEPS-1:0]  v_r;
  logic [SW-1:0]     n_r [STEPS-1];
  logic [SW-1:0]     r_r [STEPS];
  logic [SIDE_W-1:0] s_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (STEPS - 1 - i));
    logic [SW-1:0]     n_in, r_in, n_nxt, r_nxt;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;

    if (i == 0) begin : g_first
      assign n_in = in_sum;
      assign r_in = '0;
      assign s_in = {in_nm, in_point, in_flags};
      assign v_in = in_valid;
    end else begin : g_next
      assign n_in = n_r[i-1];
      assign r_in = r_r[i-1];
      assign s_in = s_r[i-1];
      assign v_in = v_r[i-1];
    end

    always_comb begin
      if (n_in >= r_in + BIT) begin
        n_nxt = n_in - (r_in + BIT);
        r_nxt = (r_in >> 1) + BIT;
      end else begin
        n_nxt = n_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i] <= r_nxt;
        s_r[i] <= s_in;
      end
    end

    if (i < STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[i] <= n_nxt;
        end
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_len   = r_r[STEPS-1][NB:0];
  assign {out_nm, out_point, out_flags} = s_r[STEPS-1];

endmodule

FILE: rtl/core/cbz_divide.sv
// ----------------------------------------------------------------------------
// cbz_divide
// Pipelined restoring divider, three lanes, one quotient bit per stage:
// q = (nm * 2^QB + len) / (2 * len).
// ----------------------------------------------------------------------------
module cbz_divide #(
  parameter int CW = cbz_pkg::COORD_WIDTH,
  parameter int NB = cbz_pkg::NORM_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [NB:0]             in_len,
  input  logic [2:0][NB-1:0]      in_nm,
  input  logic [2:0][CW-1:0]      in_point,
  input  cbz_pkg::tan_flags_t     in_flags,
  output logic                    out_valid,
  output logic [2:0][cbz_pkg::QUOT_BITS-1:0] out_quot,
  output logic [2:0][CW-1:0]      out_point,
  output cbz_pkg::tan_flags_t     out_flags
);

  localparam int QB     = cbz_pkg::QUOT_BITS;
  localparam int NW     = NB + QB + 1;
  localparam int DW     = NB + 2;
  localparam int SIDE_W = 3 * CW + $bits(cbz_pkg::tan_flags_t);

  logic [QB-1:0]        v_r;
  logic [2:0][NW-1:0]   rem_r [QB-1];
  logic [DW-1:0]        dv_r  [QB-1];
  logic [2:0][QB-1:0]   q_r   [QB];
  logic [SIDE_W-1:0]    s_r   [QB];

  for (genvar i = 0; i < QB; i++) begin : g_step
    localparam int B = QB - 1 - i;
    logic [2:0][NW-1:0] rem_in, rem_nxt;
    logic [2:0][QB-1:0] q_in, q_nxt;
    logic [DW-1:0]      dv_in;
    logic [SIDE_W-1:0]  s_in;
    logic               v_in;

    if (i == 0) begin : g_first
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign rem_in[k] = (NW'(in_nm[k]) << QB) + NW'(in_len);
      end
      assign q_in  = '0;
      assign dv_in = {in_len, 1'b0};
      assign s_in  = {in_point, in_flags};
      assign v_in  = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
      assign dv_in  = dv_r[i-1];
      assign s_in   = s_r[i-1];
      assign v_in   = v_r[i-1];
    end

    always_comb begin
      logic [NW-1:0] dsh;
      dsh = NW'(dv_in) << B;
      for (int k = 0; k < 3; k++) begin
        if (rem_in[k] >= dsh) begin
          rem_nxt[k] = rem_in[k] - dsh;
          q_nxt[k]   = q_in[k] | (QB'(1) << B);
        end else begin
          rem_nxt[k] = rem_in[k];
          q_nxt[k]   = q_in[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i] <= q_nxt;
        s_r[i] <= s_in;
      end
    end

    if (i < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          dv_r[i]  <= dv_in;
        end
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_quot  = q_r[QB-1];
  assign {out_point, out_flags} = s_r[QB-1];

endmodule

FILE: rtl/core/cubic_bezier_point_tangent.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_tangent
// Pipeline: interpolation, normalize, square root, divide, output register.
// Throughput: one word per cycle while the skid buffer is empty; while a
// result waits at the output, a one-word skid buffer takes the next one,
// and then the pipeline and in_ready hold until the skid buffer drains.
// Reset: synchronous active-low; clears valids and the control points.
// ----------------------------------------------------------------------------
module cubic_bezier_point_tangent #(
  parameter int COORD_WIDTH = cbz_pkg::COORD_WIDTH,
  parameter int PARAM_BITS  = cbz_pkg::PARAM_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cbz_pkg::ADDR_WIDTH-1:0]      paddr,
  input  logic [cbz_pkg::DATA_WIDTH-1:0]      pwdata,
  output logic [cbz_pkg::DATA_WIDTH-1:0]      prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [PARAM_BITS:0]                 in_curve_param,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_WIDTH-1:0]       out_point_x,
  output logic signed [COORD_WIDTH-1:0]       out_point_y,
  output logic signed [COORD_WIDTH-1:0]       out_point_z,
  output logic signed [cbz_pkg::TAN_WIDTH-1:0] out_tangent_x,
  output logic signed [cbz_pkg::TAN_WIDTH-1:0] out_tangent_y,
  output logic signed [cbz_pkg::TAN_WIDTH-1:0] out_tangent_z,
  output logic                                out_tangent_degenerate
);

  localparam int CW    = COORD_WIDTH;
  localparam int NB    = cbz_pkg::NORM_BITS;
  localparam int TW    = cbz_pkg::TAN_WIDTH;
  localparam int QB    = cbz_pkg::QUOT_BITS;
  localparam int CPW   = cbz_pkg::CP_WIDTH;
  localparam int DATW  = cbz_pkg::DATA_WIDTH;
  localparam int AW    = cbz_pkg::ADDR_WIDTH;
  localparam int EXW   = 64 + 3 * CW;
  localparam int RES_W = 3 * CW + 3 * TW + 1;

  // config registers
  logic [CPW-1:0]          cp_r [4];
  cbz_pkg::reg_idx_t       reg_idx;
  logic                    cfg_wr;
  logic [3:0][2:0][CW-1:0] cp_co;

  assign pready  = 1'b1;
  assign reg_idx = cbz_pkg::reg_idx_t'(paddr[AW-1:AW-2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < 4; p++) begin
        cp_r[p] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        cbz_pkg::REG_CP0: cp_r[0] <= pwdata[CPW-1:0];
        cbz_pkg::REG_CP1: cp_r[1] <= pwdata[CPW-1:0];
        cbz_pkg::REG_CP2: cp_r[2] <= pwdata[CPW-1:0];
        cbz_pkg::REG_CP3: cp_r[3] <= pwdata[CPW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cbz_pkg::REG_CP0: prdata = DATW'(cp_r[0]);
      cbz_pkg::REG_CP1: prdata = DATW'(cp_r[1]);
      cbz_pkg::REG_CP2: prdata = DATW'(cp_r[2]);
      cbz_pkg::REG_CP3: prdata = DATW'(cp_r[3]);
    endcase
  end

  // fields past bit 59 read as zero
  always_comb begin
    logic [EXW-1:0] ext;
    for (int p = 0; p < 4; p++) begin
      ext = EXW'(cp_r[p]);
      for (int k = 0; k < 3; k++) begin
        cp_co[p][k] = ext[k*CW +: CW];
      end
    end
  end

  // pipeline
  logic                en;
  logic                c_v, n_v, s_v, d_v;
  logic [2:0][CW-1:0]  c_pt, n_pt, s_pt, d_pt;
  logic [2:0][CW:0]    c_mag;
  cbz_pkg::tan_flags_t c_fl, n_fl, s_fl, d_fl;
  logic [2*NB+1:0]     n_sum;
  logic [2:0][NB-1:0]  n_nm, s_nm;
  logic [NB:0]         s_len;
  logic [2:0][QB-1:0]  d_q;

  cbz_casteljau #(.CW(CW), .PB(PARAM_BITS)) u_casteljau (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid), .in_t(in_curve_param), .cp(cp_co),
    .out_valid(c_v), .out_point(c_pt), .out_mag(c_mag), .out_flags(c_fl)
  );

  cbz_normalize #(.CW(CW), .NB(NB)) u_normalize (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(c_v), .in_point(c_pt), .in_mag(c_mag), .in_flags(c_fl),
    .out_valid(n_v), .out_sum(n_sum), .out_nm(n_nm), .out_point(n_pt), .out_flags(n_fl)
  );

  cbz_isqrt #(.CW(CW), .NB(NB)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(n_v), .in_sum(n_sum), .in_nm(n_nm), .in_point(n_pt), .in_flags(n_fl),
    .out_valid(s_v), .out_len(s_len), .out_nm(s_nm), .out_point(s_pt), .out_flags(s_fl)
  );

  cbz_divide #(.CW(CW), .NB(NB)) u_divide (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s_v), .in_len(s_len), .in_nm(s_nm), .in_point(s_pt), .in_flags(s_fl),
    .out_valid(d_v), .out_quot(d_q), .out_point(d_pt), .out_flags(d_fl)
  );

  // result formatting
  logic [RES_W-1:0]   res_nxt;
  logic [2:0][TW-1:0] tan_nxt;

  always_comb begin
    logic [TW-1:0] mq;
    for (int k = 0; k < 3; k++) begin
      mq = TW'(d_q[k]);
      if (d_fl.degen) begin
        tan_nxt[k] = '0;
      end else if (d_fl.neg[k]) begin
        tan_nxt[k] = TW'(-mq);
      end else begin
        tan_nxt[k] = mq;
      end
    end
    res_nxt = {d_pt[0], d_pt[1], d_pt[2], tan_nxt[0], tan_nxt[1], tan_nxt[2], d_fl.degen};
  end

  // output register and skid buffer
  logic             out_v_r, out_v_nxt, skid_v_r, skid_v_nxt, slot_free;
  logic [RES_W-1:0] out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;

  assign en        = !skid_v_r;
  assign in_ready  = en;
  assign slot_free = !out_v_r || out_ready;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (slot_free) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = d_v;
        out_d_nxt = res_nxt;
      end
    end else if (!skid_v_r && d_v) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid = out_v_r;
  assign {out_point_x, out_point_y, out_point_z,
          out_tangent_x, out_tangent_y, out_tangent_z,
          out_tangent_degenerate} = out_d_r;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a word while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ready))
    else $error("skid filled without output stall");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_tangent_degenerate |->
      out_tangent_x == '0 && out_tangent_y == '0 && out_tangent_z == '0)
    else $error("degenerate tangent not zero");

endmodule

FILE: test/bezier_eval_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bezier_eval_checker
// Watches the parameter and result channels and the register port of the
// cubic Bezier evaluator. It recomputes the curve point and the unit tangent
// for every accepted parameter word. Each result word is then compared, field
// by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module bezier_eval_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic                                  pready,
  input  logic [cbz_pkg::ADDR_WIDTH-1:0]        paddr,
  input  logic [cbz_pkg::DATA_WIDTH-1:0]        pwdata,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [cbz_pkg::PARAM_BITS:0]          in_curve_param,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [cbz_pkg::COORD_WIDTH-1:0] out_point_x,
  input  logic signed [cbz_pkg::COORD_WIDTH-1:0] out_point_y,
  input  logic signed [cbz_pkg::COORD_WIDTH-1:0] out_point_z,
  input  logic signed [cbz_pkg::TAN_WIDTH-1:0]  out_tangent_x,
  input  logic signed [cbz_pkg::TAN_WIDTH-1:0]  out_tangent_y,
  input  logic signed [cbz_pkg::TAN_WIDTH-1:0]  out_tangent_z,
  input  logic                                  out_tangent_degenerate,
  output int                                    fail_count,
  output int                                    points_pending,
  output int                                    points_checked,
  output int                                    degenerate_seen
);

  localparam int CW  = cbz_pkg::COORD_WIDTH;
  localparam int PB  = cbz_pkg::PARAM_BITS;
  localparam int TW  = cbz_pkg::TAN_WIDTH;
  localparam int NB  = cbz_pkg::NORM_BITS;
  localparam int QB  = cbz_pkg::QUOT_BITS;
  localparam int CPW = cbz_pkg::CP_WIDTH;
  localparam int AW  = cbz_pkg::ADDR_WIDTH;

  typedef struct {
    logic signed [CW-1:0] pt [3];
    logic signed [TW-1:0] tan [3];
    logic                 degen;
  } curve_sample_t;

  logic [CPW-1:0] ctrl_pts [4];
  curve_sample_t  pending_points [$];

  function automatic longint coord(logic [CPW-1:0] cp, int k);
    logic signed [CW-1:0] f;
    f = cp[k*CW +: CW];
    return f;
  endfunction

  // a + (b - a) * t / 2^16, rounded half up
  function automatic longint lerp(longint a, longint b, longint t);
    longint prod;
    prod = (b - a) * t;
    return a + ((prod + (64'sd1 <<< (PB - 1))) >>> PB);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= res + probe) begin
        n -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  function automatic curve_sample_t eval_curve(logic [PB:0] t_in);
    curve_sample_t   s;
    longint          t, a, b, c, d, e;
    longint          diff [3];
    longint unsigned mag [3];
    longint unsigned maxm, sum, len, q;
    t = (t_in > (1 << PB)) ? (1 << PB) : t_in;
    maxm = 0;
    for (int k = 0; k < 3; k++) begin
      a = lerp(coord(ctrl_pts[0], k), coord(ctrl_pts[1], k), t);
      b = lerp(coord(ctrl_pts[1], k), coord(ctrl_pts[2], k), t);
      c = lerp(coord(ctrl_pts[2], k), coord(ctrl_pts[3], k), t);
      d = lerp(a, b, t);
      e = lerp(b, c, t);
      s.pt[k] = CW'(lerp(d, e, t));
      diff[k] = e - d;
      mag[k] = (diff[k] < 0) ? -diff[k] : diff[k];
      if (mag[k] > maxm) maxm = mag[k];
    end
    s.degen = (maxm == 0);
    for (int k = 0; k < 3; k++) s.tan[k] = '0;
    if (!s.degen) begin
      while (maxm >= (64'd1 << NB)) begin
        maxm >>= 1;
        for (int k = 0; k < 3; k++) mag[k] >>= 1;
      end
      while (maxm < (64'd1 << (NB - 1))) begin
        maxm <<= 1;
        for (int k = 0; k < 3; k++) mag[k] <<= 1;
      end
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      len = int_sqrt(sum);
      for (int k = 0; k < 3; k++) begin
        q = ((mag[k] << QB) + len) / (2 * len);
        s.tan[k] = TW'((diff[k] < 0) ? -q : q);
      end
    end
    return s;
  endfunction

  assign points_pending = pending_points.size();

  always @(posedge clk) begin
    curve_sample_t exp_s;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) ctrl_pts[i] <= '0;
      fail_count <= 0;
      points_checked <= 0;
      degenerate_seen <= 0;
      pending_points.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        ctrl_pts[paddr[AW-1:3]] <= pwdata[CPW-1:0];
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          $error("unexpected result word");
          fail_count <= fail_count + 1;
        end else begin
          exp_s = pending_points.pop_front();
          points_checked <= points_checked + 1;
          if (out_tangent_degenerate) degenerate_seen <= degenerate_seen + 1;
          if (out_point_x !== exp_s.pt[0] || out_point_y !== exp_s.pt[1] ||
              out_point_z !== exp_s.pt[2] || out_tangent_x !== exp_s.tan[0] ||
              out_tangent_y !== exp_s.tan[1] || out_tangent_z !== exp_s.tan[2] ||
              out_tangent_degenerate !== exp_s.degen)
            fail_count <= fail_count + 1;
          if (out_point_x !== exp_s.pt[0])
            $error("point_x exp %0d got %0d", exp_s.pt[0], out_point_x);
          if (out_point_y !== exp_s.pt[1])
            $error("point_y exp %0d got %0d", exp_s.pt[1], out_point_y);
          if (out_point_z !== exp_s.pt[2])
            $error("point_z exp %0d got %0d", exp_s.pt[2], out_point_z);
          if (out_tangent_x !== exp_s.tan[0])
            $error("tangent_x exp %0d got %0d", exp_s.tan[0], out_tangent_x);
          if (out_tangent_y !== exp_s.tan[1])
            $error("tangent_y exp %0d got %0d", exp_s.tan[1], out_tangent_y);
          if (out_tangent_z !== exp_s.tan[2])
            $error("tangent_z exp %0d got %0d", exp_s.tan[2], out_tangent_z);
          if (out_tangent_degenerate !== exp_s.degen)
            $error("tangent_degenerate exp %0b got %0b", exp_s.degen,
                   out_tangent_degenerate);
        end
      end
      if (in_valid && in_ready)
        pending_points = {pending_points, eval_curve(in_curve_param)};
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the cubic Bezier evaluator through a series of control point sets:
// reset values, extreme coordinates, coincident points and random curves.
// Directed curve parameters go to the first three sets, random ones to the
// rest, with random gaps on the sender and random stalls on the receiver in
// most sets; a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CW  = cbz_pkg::COORD_WIDTH;
  localparam int PB  = cbz_pkg::PARAM_BITS;
  localparam int TW  = cbz_pkg::TAN_WIDTH;
  localparam int AW  = cbz_pkg::ADDR_WIDTH;
  localparam int DW  = cbz_pkg::DATA_WIDTH;
  localparam int CPW = cbz_pkg::CP_WIDTH;
  localparam int TPW = PB + 1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0]        paddr = '0;
  logic [DW-1:0]        pwdata = '0;
  logic [DW-1:0]        prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PB:0]          in_curve_param = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [CW-1:0] out_point_x, out_point_y, out_point_z;
  logic signed [TW-1:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic                 out_tangent_degenerate;
  int                   fail_count, points_pending, points_checked;
  int                   degenerate_seen;
  int                   stall_mode = 0, stall_left = 0, gap_mode = 0;
  int                   params_sent = 0, curve_sets = 0;

  localparam int ONE = 1 << PB;
  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cubic_bezier_point_tangent u_top (.*);

  bezier_eval_checker u_checker (.*);

  initial begin
    #400000;
    $display("** cubic_bezier_point_tangent: FAILED **");
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_mode == 0) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(9) < 3) begin
      stall_left <= ($urandom_range(19) == 0) ? $urandom_range(60, 20)
                                              : $urandom_range(3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [DW-1:0] pack_point(logic [CW-1:0] x,
      logic [CW-1:0] y, logic [CW-1:0] z);
    return {{(DW-CPW){1'b0}}, z, y, x};
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return CMAX;
      1: return CMIN;
      2: return CW'($urandom_range(255));
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic write_ctrl_pt(cbz_pkg::reg_idx_t idx, logic [DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_curve(logic [DW-1:0] p0, logic [DW-1:0] p1,
      logic [DW-1:0] p2, logic [DW-1:0] p3);
    write_ctrl_pt(cbz_pkg::REG_CP0, p0);
    write_ctrl_pt(cbz_pkg::REG_CP1, p1);
    write_ctrl_pt(cbz_pkg::REG_CP2, p2);
    write_ctrl_pt(cbz_pkg::REG_CP3, p3);
    curve_sets++;
  endtask

  task automatic send_param(logic [PB:0] t);
    int gap;
    gap = 0;
    if (gap_mode != 0) begin
      case ($urandom_range(19))
        0: gap = $urandom_range(40, 10);
        1, 2, 3, 4, 5: gap = $urandom_range(3, 1);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_curve_param <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    params_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [PB:0] rand_param();
    case ($urandom_range(9))
      0: return TPW'($urandom_range(2 * ONE - 1));
      1: return ($urandom_range(1) != 0) ? TPW'(ONE) : '0;
      default: return TPW'($urandom_range(ONE));
    endcase
  endfunction

  task automatic random_params(int n);
    repeat (n) begin
      if ($urandom_range(49) == 0) begin
        gap_mode = $urandom_range(2);
        stall_mode = $urandom_range(2);
      end
      send_param(rand_param());
    end
  endtask

  initial begin
    logic [PB:0] dir_params [8];
    dir_params = '{'0, TPW'(1), TPW'(ONE / 2), TPW'(ONE - 1), TPW'(ONE), TPW'(ONE + 1),
                   TPW'(2 * ONE - 1), 17'h0AAAA};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset control points: every tangent degenerate
    foreach (dir_params[i]) send_param(dir_params[i]);
    drain();

    // extreme corners, one curve each way
    load_curve(pack_point(CMIN, CMIN, CMIN), pack_point(CMAX, CMIN, CMAX),
               pack_point(CMIN, CMAX, CMIN), pack_point(CMAX, CMAX, CMAX));
    gap_mode = 1;
    stall_mode = 1;
    foreach (dir_params[i]) send_param(dir_params[i]);
    drain();

    // first three points coincide: degenerate near t = 0
    load_curve(pack_point(20'h00100, CMAX, CMIN), pack_point(20'h00100, CMAX, CMIN),
               pack_point(20'h00100, CMAX, CMIN), pack_point(20'h00200, '0, 20'h00001));
    send_param('0);
    send_param(TPW'(1));
    send_param(TPW'(ONE));
    drain();

    // random curves with random content, then one with every point at CMAX
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) begin
        load_curve(pack_point(CMAX, CMAX, CMAX), pack_point(CMAX, CMAX, CMAX),
                   pack_point(CMAX, CMAX, CMAX), pack_point(CMAX, CMAX, CMAX));
      end else begin
        load_curve(pack_point(rand_coord(), rand_coord(), rand_coord()),
                   pack_point(rand_coord(), rand_coord(), rand_coord()),
                   pack_point(rand_coord(), rand_coord(), rand_coord()),
                   pack_point(rand_coord(), rand_coord(), rand_coord()));
      end
      gap_mode = phase % 3;
      stall_mode = (phase + 1) % 3;
      random_params((phase == 5) ? 30 : 80);
      drain();
    end

    $display("Sent %0d curve parameters over %0d control point sets.", params_sent,
             curve_sets);
    $display("Checked %0d result words, %0d with a degenerate tangent.",
             points_checked, degenerate_seen);
    if (fail_count == 0 && points_pending == 0) begin
      $display("** cubic_bezier_point_tangent: PASSED **");
    end else begin
      $display("** cubic_bezier_point_tangent: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/cbz_pkg.sv
rtl/core/cbz_casteljau.sv
rtl/core/cbz_normalize.sv
rtl/core/cbz_isqrt.sv
rtl/core/cbz_divide.sv
rtl/core/cubic_bezier_point_tangent.sv
test/bezier_eval_checker.sv
test/testbench.sv
